@@ design/meg_pkg.sv @@
// meg_pkg: shared types and constants for the motion event gate
// holds the config bundle, the queued result command and the register/kind codes
// no dependencies
`default_nettype none

package meg_pkg;

    localparam int CFG_MS_W   = 22;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int RUN_W      = 8;
    localparam int KIND_W     = 2;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EVENT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_DOWN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTION      = 2'd3;

    // reset values of the registers
    localparam logic [CFG_MS_W-1:0] RST_LOOKBACK_WINDOW = 22'd3000;
    localparam logic [CFG_MS_W-1:0] RST_MIN_EVENT       = 22'd10000;
    localparam logic [CFG_MS_W-1:0] RST_COOL_DOWN       = 22'd300000;
    localparam logic [RUN_W-1:0]    RST_MIN_MOTION      = 8'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

    typedef struct packed {
        logic [CFG_MS_W-1:0] lookback_window_ms;
        logic [CFG_MS_W-1:0] min_event_ms;
        logic [CFG_MS_W-1:0] cool_down_ms;
        logic [RUN_W-1:0]    min_motion_frames;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/meg_if.sv @@
// meg_if: valid/ready channel interfaces of the motion event gate
// frame input, result output and config write channels; uses meg_pkg widths
`default_nettype none

interface meg_frame_if;
    logic                       valid;
    logic                       ready;
    logic [meg_pkg::TAG_W-1:0]  frame_tag;
    logic [meg_pkg::TIME_W-1:0] capture_time_ms;
    logic                       motion_seen;

    modport source (output valid, output frame_tag, output capture_time_ms,
                    output motion_seen, input ready);
    modport sink   (input valid, input frame_tag, input capture_time_ms,
                    input motion_seen, output ready);
endinterface

interface meg_result_if;
    logic                       valid;
    logic                       ready;
    logic [meg_pkg::KIND_W-1:0] result_kind;
    logic [meg_pkg::TAG_W-1:0]  out_frame_tag;
    logic                       last_of_run;

    modport source (output valid, output result_kind, output out_frame_tag,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input out_frame_tag,
                    input last_of_run, output ready);
endinterface

interface meg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [meg_pkg::CFG_IDX_W-1:0]  index;
    logic [meg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/meg_front.sv @@
// meg_front: accepts frames, keeps the lookback ring and the event state,
// and sequences result commands into the queue; uses meg_pkg and meg_frame_if
`default_nettype none

module meg_front
    import meg_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    meg_frame_if.sink    frame,
    input  cfg_t         cfg,
    output logic         push,
    output cmd_t         push_cmd,
    input  logic         q_full
);

    localparam int PTR_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(RING_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RDTIM = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    logic [TIME_W-1:0] ring_time [RING_DEPTH];
    logic [TAG_W-1:0]  ring_tag  [RING_DEPTH];

    logic [1:0]          state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                open_reg, open_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [TIME_W-1:0]   lmt_reg, lmt_next;
    logic [CFG_MS_W-1:0] cool_reg, cool_next;
    logic                drain_all_reg, drain_all_next;

    logic [TIME_W-1:0]   now_reg;
    logic                motion_reg;
    logic [TIME_W-1:0]   time_q;
    logic [TAG_W-1:0]    tag_q;

    logic                wr_en;
    logic [PTR_W-1:0]    slot;
    logic [SUM_W-1:0]    slot_sum;
    logic [TIME_W-1:0]   span;
    logic [TIME_W-1:0]   since_motion;
    logic [RUN_W-1:0]    need;
    logic [CNT_W-1:0]    cnt_eval;
    logic                start_new;
    logic                active;
    logic                drain_last;

    assign frame.ready = (state_reg == ST_IDLE);
    assign need = (cfg.min_motion_frames == '0) ? RUN_W'(1) : cfg.min_motion_frames;
    assign slot_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign span = now_reg - time_q;
    assign drain_last = !drain_all_reg || (count_reg == CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        open_next      = open_reg;
        run_next       = run_reg;
        lmt_next       = lmt_reg;
        cool_next      = cool_reg;
        drain_all_next = drain_all_reg;
        push           = 1'b0;
        push_cmd       = '0;
        wr_en          = 1'b0;
        slot           = '0;
        start_new      = 1'b0;
        active         = 1'b0;
        since_motion   = '0;
        cnt_eval       = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (frame.valid)
                begin
                    wr_en = 1'b1;
                    if (count_reg == FULL_CNT)
                    begin
                        // full ring: oldest goes, new word lands in its place
                        slot      = head_reg;
                        head_next = ptr_inc(head_reg);
                    end
                    else
                    begin
                        slot = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM)
                                                       : PTR_W'(slot_sum);
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_RDTIM;
                end
            end

            ST_RDTIM:
            begin
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (!q_full)
                begin
                    if (span > TIME_W'(cfg.lookback_window_ms))
                    begin
                        head_next = ptr_inc(head_reg);
                        cnt_eval  = count_reg - 1'b1;
                    end
                    count_next = cnt_eval;
                    state_next = ST_IDLE;

                    if (TIME_W'(cool_reg) > span)
                    begin
                        cool_next = cool_reg - span[CFG_MS_W-1:0];
                    end
                    else
                    begin
                        cool_next = '0;
                        if (motion_reg)
                        begin
                            if (run_reg != RUN_MAX)
                            begin
                                run_next  = run_reg + 1'b1;
                                start_new = (run_next == need);
                            end
                            if (run_next >= need)
                            begin
                                lmt_next = now_reg;
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end

                        since_motion = now_reg - lmt_next;
                        active = open_reg && (since_motion < TIME_W'(cfg.min_event_ms));

                        if (!active)
                        begin
                            if (open_reg)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = KIND_END;
                                push_cmd.last = 1'b1;
                                open_next     = 1'b0;
                                cool_next     = cfg.cool_down_ms;
                            end
                            else if (start_new)
                            begin
                                push           = 1'b1;
                                push_cmd.kind  = KIND_START;
                                push_cmd.last  = (cnt_eval == '0);
                                open_next      = 1'b1;
                                drain_all_next = 1'b1;
                                if (cnt_eval != '0)
                                begin
                                    state_next = ST_DRAIN;
                                end
                            end
                        end
                        else if (cnt_eval != '0)
                        begin
                            drain_all_next = 1'b0;
                            state_next     = ST_DRAIN;
                        end
                    end
                end
            end

            ST_DRAIN:
            begin
                if (!q_full)
                begin
                    push          = 1'b1;
                    push_cmd.kind = KIND_FRAME;
                    push_cmd.tag  = tag_q;
                    push_cmd.last = drain_last;
                    head_next     = ptr_inc(head_reg);
                    count_next    = count_reg - 1'b1;
                    if (drain_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            open_reg      <= 1'b0;
            run_reg       <= '0;
            lmt_reg       <= '0;
            cool_reg      <= '0;
            drain_all_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            run_reg       <= run_next;
            lmt_reg       <= lmt_next;
            cool_reg      <= cool_next;
            drain_all_reg <= drain_all_next;
        end
    end

    // latched frame word
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            now_reg    <= frame.capture_time_ms;
            motion_reg <= frame.motion_seen;
        end
    end

    // ring memory: one write port, read always follows the next head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_time[slot] <= frame.capture_time_ms;
            ring_tag[slot]  <= frame.frame_tag;
        end
        time_q <= ring_time[head_next];
        tag_q  <= ring_tag[head_next];
    end

endmodule

`default_nettype wire

@@ design/meg_cmdq.sv @@
// meg_cmdq: short command queue between the sequencer and the output stage
// uses meg_pkg for the command word
`default_nettype none

module meg_cmdq
    import meg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push, do_pop;

    assign full    = (fill_reg == QCNT_W'(QDEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/meg_back.sv @@
// meg_back: output register stage that turns queued commands into result words
// uses meg_pkg and meg_result_if
`default_nettype none

module meg_back
    import meg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic          q_empty,
    output logic          pop,
    meg_result_if.source  result
);

    logic valid_reg;
    cmd_t out_reg;

    assign pop = !q_empty && (!valid_reg || result.ready);

    assign result.valid         = valid_reg;
    assign result.result_kind   = out_reg.kind;
    // only forwarded frames carry a tag
    assign result.out_frame_tag = (out_reg.kind == KIND_FRAME) ? out_reg.tag : '0;
    assign result.last_of_run   = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/motion_event_gate.sv @@
// motion_event_gate top level: config registers, front sequencer, queue, output stage
// depends on meg_pkg, meg_if, meg_front, meg_cmdq and meg_back
//
// Takes one video frame word at a time (tag, capture time, motion bit) and gates
// the stream into motion events: a start mark followed by the buffered lookback
// frames, one forwarded frame per input while the event lasts, and an end mark.
// A frame is taken only in the idle state; the next waits while it passes the ring read
// and evaluate states and, if it forwards buffered frames (one, or all N on an event
// start), a drain state fed by the single read port of the lookback ring, which yields
// one tag per cycle while the queue has room. Results sit in a 4-entry queue and
// an output register, so a stalled result side holds the front only once the queue
// fills. Config writes are always ready and must be issued only while the block is idle.
`default_nettype none

module motion_event_gate
    import meg_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    meg_frame_if.sink     frame,
    meg_result_if.source  result,
    meg_cfg_if.sink       cfg
);

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t pop_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lookback_window_ms <= RST_LOOKBACK_WINDOW;
            cfg_reg.min_event_ms       <= RST_MIN_EVENT;
            cfg_reg.cool_down_ms       <= RST_COOL_DOWN;
            cfg_reg.min_motion_frames  <= RST_MIN_MOTION;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOOKBACK_WINDOW: cfg_reg.lookback_window_ms <= cfg.data;
                REG_MIN_EVENT:       cfg_reg.min_event_ms       <= cfg.data;
                REG_COOL_DOWN:       cfg_reg.cool_down_ms       <= cfg.data;
                REG_MIN_MOTION:      cfg_reg.min_motion_frames  <= cfg.data[RUN_W-1:0];
                default:             ;
            endcase
        end
    end

    meg_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .cfg      (cfg_reg),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    meg_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    meg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pop_cmd),
        .q_empty (q_empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ tb/tb_motion_event_gate.sv @@
`timescale 1ns / 100ps
// tb_motion_event_gate: self-checking bench for the motion event gate, with an
// in-bench model of the lookback ring, event and cooldown logic to predict results
// depends on meg_pkg, meg_if and motion_event_gate

module tb_motion_event_gate;
    import meg_pkg::*;

    localparam int RING_DEPTH     = 32;
    localparam int RPTR_W         = $clog2(RING_DEPTH);
    localparam int RCNT_W         = $clog2(RING_DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] ms;
        logic              motion;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    meg_frame_if  frame_ch ();
    meg_result_if result_ch ();
    meg_cfg_if    cfg_ch ();

    motion_event_gate #(
        .RING_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // gate model state
    cfg_t                            gate_cfg;
    logic [TIME_W-1:0]               ring_ms   [RING_DEPTH];
    logic [TAG_W-1:0]                ring_tags [RING_DEPTH];
    logic [RPTR_W-1:0]               ring_first;
    logic [RCNT_W-1:0]               ring_fill;
    logic                            event_open;
    logic [RUN_W-1:0]                motion_run;
    logic [TIME_W-1:0]               last_motion_ms;
    logic [TIME_W-1:0]               cooldown_left;

    cmd_t        gate_outputs_due [$];
    frame_word_t frames_to_send [$];

    int frames_queued   = 0;
    int frames_accepted = 0;
    int results_seen    = 0;
    int fail_count      = 0;
    int idle_cycles     = 0;
    int hold_at         = 32'h7fff_ffff;
    logic frame_took    = 1'b0;
    logic [TIME_W-1:0] capture_ms = '0;

    function automatic void drop_oldest_frame();
        if (ring_fill != 0)
        begin
            ring_first = RPTR_W'((ring_first + 1) % RING_DEPTH);
            ring_fill  = ring_fill - 1'b1;
        end
    endfunction

    // one frame through the gate: ring update, cooldown, motion run, event marks
    function automatic void gate_frame(input frame_word_t fw);
        logic [TIME_W-1:0] span;
        logic [RUN_W-1:0]  need;
        logic              start_new;
        logic              active;
        int                slot;
        cmd_t              run_q [$];

        need      = (gate_cfg.min_motion_frames == 0) ? RUN_W'(1)
                                                      : gate_cfg.min_motion_frames;
        start_new = 1'b0;

        if (ring_fill >= RING_DEPTH)
            drop_oldest_frame();
        slot            = (ring_first + ring_fill) % RING_DEPTH;
        ring_ms[slot]   = fw.ms;
        ring_tags[slot] = fw.tag;
        ring_fill       = ring_fill + 1'b1;

        // span taken before the window drop, and it also drains the cooldown
        span = fw.ms - ring_ms[ring_first];
        if (span > gate_cfg.lookback_window_ms)
            drop_oldest_frame();

        if (cooldown_left > span)
        begin
            cooldown_left = cooldown_left - span;
            return;
        end
        cooldown_left = '0;

        if (fw.motion)
        begin
            if (motion_run != RUN_MAX)
            begin
                motion_run = motion_run + 1'b1;
                start_new  = (motion_run == need);
            end
            if (motion_run >= need)
                last_motion_ms = fw.ms;
        end
        else
            motion_run = '0;

        active = event_open && ((fw.ms - last_motion_ms) < gate_cfg.min_event_ms);

        if (!active)
        begin
            if (event_open)
            begin
                run_q.push_back('{KIND_END, '0, 1'b0});
                event_open    = 1'b0;
                cooldown_left = gate_cfg.cool_down_ms;
            end
            else if (start_new)
            begin
                run_q.push_back('{KIND_START, '0, 1'b0});
                event_open = 1'b1;
                while (ring_fill != 0)
                begin
                    run_q.push_back('{KIND_FRAME, ring_tags[ring_first], 1'b0});
                    drop_oldest_frame();
                end
            end
        end
        else if (ring_fill != 0)
        begin
            run_q.push_back('{KIND_FRAME, ring_tags[ring_first], 1'b0});
            drop_oldest_frame();
        end

        if (run_q.size() != 0)
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            gate_outputs_due.push_back(run_q[i]);
    endfunction

    // frame sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin : frame_sender
        frame_word_t fw;
        if (rst_n && (!frame_ch.valid || frame_took))
        begin
            if (burst_left == 0 && gap_left > 0)
            begin
                gap_left = gap_left - 1;
                frame_ch.valid <= 1'b0;
            end
            else if (frames_to_send.size() != 0)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                burst_left = burst_left - 1;
                fw = frames_to_send[0];
                frames_to_send.delete(0);
                frame_ch.valid           <= 1'b1;
                frame_ch.frame_tag       <= fw.tag;
                frame_ch.capture_time_ms <= fw.ms;
                frame_ch.motion_seen     <= fw.motion;
            end
            else
                frame_ch.valid <= 1'b0;
        end
    end

    // result receiver: stall modes that change now and then, plus one long hold
    int         mode_left     = 0;
    int         stall_mode    = 0;
    int         hold_left     = 0;
    logic       hold_done     = 1'b0;
    logic [7:0] stall_pattern = 8'b1011_0010;

    always @(negedge clk)
    begin : result_receiver
        logic rdy;
        rdy = 1'b0;
        if (rst_n)
        begin
            if (!hold_done && results_seen >= hold_at)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
                hold_left = hold_left - 1;
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 128);
                end
                mode_left = mode_left - 1;
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 1) == 1);
                    default:
                    begin
                        rdy           = stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                endcase
            end
        end
        result_ch.ready <= rdy;
    end

    // sample handshakes, predict, compare, watchdog
    always @(posedge clk)
    begin : result_check
        cmd_t        want;
        frame_word_t fw;
        if (rst_n)
        begin
            frame_took <= frame_ch.valid && frame_ch.ready;
            if (frame_ch.valid && frame_ch.ready)
            begin
                fw = {frame_ch.frame_tag, frame_ch.capture_time_ms, frame_ch.motion_seen};
                gate_frame(fw);
                frames_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (gate_outputs_due.size() == 0)
                begin
                    $error("unexpected result word: result_kind %0d out_frame_tag %h",
                           result_ch.result_kind, result_ch.out_frame_tag);
                    fail_count++;
                end
                else
                begin
                    want = gate_outputs_due[0];
                    gate_outputs_due.delete(0);
                    if (result_ch.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.kind, result_ch.result_kind);
                        fail_count++;
                    end
                    if (result_ch.out_frame_tag !== want.tag)
                    begin
                        $error("out_frame_tag: expected %h, got %h",
                               want.tag, result_ch.out_frame_tag);
                        fail_count++;
                    end
                    if (result_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last, result_ch.last_of_run);
                        fail_count++;
                    end
                end
            end
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic queue_frame(input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] ms,
                               input logic motion);
        frames_to_send.push_back({tag, ms, motion});
        frames_queued++;
    endtask

    // motion runs and quiet stretches with random content, some noise and time jumps
    task automatic queue_frames(input int count, input int run_max, input int quiet_max,
                                input int step_max);
        int   seg;
        int   pick;
        logic motion_phase;
        logic m;
        seg          = 0;
        motion_phase = 1'b0;
        for (int k = 0; k < count; k++)
        begin
            if (seg == 0)
            begin
                motion_phase = !motion_phase;
                seg = motion_phase ? $urandom_range(1, run_max) : $urandom_range(1, quiet_max);
            end
            seg  = seg - 1;
            pick = $urandom_range(0, 49);
            if (pick == 0)
                capture_ms = $urandom;
            else if (pick == 1)
                capture_ms = capture_ms - $urandom_range(1, 5000);
            else
                capture_ms = capture_ms + $urandom_range(0, step_max);
            m = motion_phase;
            if ($urandom_range(0, 19) == 0)
                m = !m;
            queue_frame(TAG_W'($urandom), capture_ms, m);
        end
    endtask

    task automatic wait_drained(input int settle);
        while (frames_accepted != frames_queued || gate_outputs_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_LOOKBACK_WINDOW: gate_cfg.lookback_window_ms = value[CFG_MS_W-1:0];
            REG_MIN_EVENT:       gate_cfg.min_event_ms       = value[CFG_MS_W-1:0];
            REG_COOL_DOWN:       gate_cfg.cool_down_ms       = value[CFG_MS_W-1:0];
            REG_MIN_MOTION:      gate_cfg.min_motion_frames  = value[RUN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int window_ms, input int hold_ms, input int quiet_ms,
                              input int run_need);
        wait_drained(SETTLE_CYCLES);
        write_reg(REG_LOOKBACK_WINDOW, CFG_DATA_W'(window_ms));
        write_reg(REG_MIN_EVENT, CFG_DATA_W'(hold_ms));
        write_reg(REG_COOL_DOWN, CFG_DATA_W'(quiet_ms));
        write_reg(REG_MIN_MOTION, CFG_DATA_W'(run_need));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        frame_ch.valid           = 1'b0;
        frame_ch.frame_tag       = '0;
        frame_ch.capture_time_ms = '0;
        frame_ch.motion_seen     = 1'b0;
        result_ch.ready          = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        rst_n                    = 1'b0;

        gate_cfg       = '{RST_LOOKBACK_WINDOW, RST_MIN_EVENT, RST_COOL_DOWN, RST_MIN_MOTION};
        ring_first     = '0;
        ring_fill      = '0;
        event_open     = 1'b0;
        motion_run     = '0;
        last_motion_ms = '0;
        cooldown_left  = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: open an event, forward, go stale, cooldown, wrap in time
        queue_frame(16'h0000, 32'd0, 1'b0);
        queue_frame(16'hFFFF, 32'd100, 1'b1);
        queue_frame(16'h1234, 32'd200, 1'b1);
        queue_frame(16'hABCD, 32'd300, 1'b1);
        queue_frame(16'h5555, 32'd400, 1'b1);
        queue_frame(16'h0001, 32'd11000, 1'b0);
        queue_frame(16'h0002, 32'd11100, 1'b1);
        queue_frame(16'h0003, 32'hFFFF_FFFF, 1'b1);
        queue_frame(16'h0004, 32'd5, 1'b1);
        queue_frame(16'h0005, 32'd10, 1'b1);
        queue_frame(16'h0006, 32'd4, 1'b0);

        // low extremes, run length of zero acts as one
        set_config(0, 1, 1, 0);
        queue_frame(16'h8000, 32'h8000_0000, 1'b1);
        queue_frame(16'h7FFF, 32'h8000_0000, 1'b1);
        queue_frame(16'h00FF, 32'h8000_0001, 1'b0);
        queue_frame(16'hFF00, 32'h8000_0002, 1'b1);
        queue_frame(16'h0F0F, 32'h8000_0002, 1'b1);
        capture_ms = 32'h8000_0010;
        queue_frames(24, 4, 4, 20);
        capture_ms = capture_ms + 1000;
        queue_frame(TAG_W'($urandom), capture_ms, 1'b0);

        // high extremes: full ring, run saturates, start drains the whole ring
        set_config(3600000, 3600000, 3600000, 255);
        hold_at = results_seen + 12;
        for (int k = 0; k < 270; k++)
        begin
            capture_ms = capture_ms + $urandom_range(1, 20);
            queue_frame(TAG_W'($urandom), capture_ms, k < 262);
        end

        set_config(400, 500, 1000, 3);
        queue_frames(24, 6, 12, 100);
        // sender waits for every result before going on
        wait_drained(0);
        queue_frames(24, 6, 12, 100);

        set_config(2000, 3000, 20000, 5);
        queue_frames(24, 10, 15, 250);

        set_config(100000, 200, 1, 1);
        queue_frames(20, 3, 40, 20);

        wait_drained(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
